// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the automatic headlight controller RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define AHC_ASSERT_SAME(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Property that must hold in the cycle after its trigger.
`define AHC_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/ahc_pkg.sv =====
// Types, constants and helper functions for the automatic headlight controller.
// Used by every module of the block; depends on nothing else.
package ahc_pkg;

    localparam int NUM_SW = 5;
    localparam int NUM_TIMERS = 4;
    localparam int NUM_PULSES = 3;

    localparam int SW_LOCK = 0;
    localparam int SW_UNLOCK = 1;
    localparam int SW_TURN = 2;
    localparam int SW_DOOR = 3;
    localparam int SW_IGN = 4;

    localparam int T_LEAVE = 0;
    localparam int T_COURTESY = 1;
    localparam int T_FOLLOW = 2;
    localparam int T_ACC = 3;

    localparam logic [31:0] DEBOUNCE_MS = 32'd30;
    localparam logic [31:0] PAIR_WINDOW_MS = 32'd1500;
    localparam logic [31:0] REARM_MS = 32'd5000;
    localparam logic [31:0] AMBIENT_STABLE_MS = 32'd2500;
    localparam logic [31:0] FAULT_STABLE_MS = 32'd4000;
    localparam logic [11:0] FAULT_LOW = 12'd5;
    localparam logic [11:0] FAULT_HIGH = 12'd1018;

    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DARK_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEAVE_LOCK_MS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEAVE_UNLOCK_MS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COURTESY_MS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOLLOW_HOME_MS = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACCESSORY_HOLD_MS = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_INVERT_MASK = 3'd7;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic        lock_level;
        logic        unlock_level;
        logic        turn_level;
        logic        door_level;
        logic        ignition_level;
        logic [9:0]  light_sample;
    } item_t;

    typedef struct packed {
        logic headlight_on;
        logic accessory_on;
        logic sensor_fault;
        logic ambient_is_dark;
    } result_t;

    typedef struct packed {
        logic [9:0]  dark_threshold;
        logic [9:0]  bright_threshold;
        logic [31:0] leave_lock_ms;
        logic [31:0] leave_unlock_ms;
        logic [31:0] courtesy_ms;
        logic [31:0] follow_home_ms;
        logic [31:0] accessory_hold_ms;
        logic [4:0]  invert_mask;
    } cfg_t;

    typedef struct packed {
        logic [NUM_SW-1:0]        debounced_level;
        logic [NUM_SW-1:0]        last_raw_level;
        logic [NUM_SW-1:0][31:0]  level_changed_time;
        logic                     dark_now;
        logic                     dark_candidate;
        logic [31:0]              dark_changed_time;
        logic                     fault_now;
        logic                     fault_candidate;
        logic [31:0]              fault_changed_time;
        logic                     ambient_ready;
    } sense_st_t;

    typedef struct packed {
        logic [NUM_TIMERS-1:0]        timer_running;
        logic [NUM_TIMERS-1:0][31:0]  timer_start_time;
        logic                         leave_uses_unlock;
        logic                         accessory_door_cycle;
        logic [NUM_PULSES-1:0]        pulse_pending;
        logic [NUM_PULSES-1:0][31:0]  pulse_time;
        logic                         door_armed;
        logic                         rearm_waiting;
        logic [31:0]                  door_closed_time;
        logic                         drive_mode_prev;
    } ctrl_st_t;

    // Elapsed time with wrap-around, limited to the time mask.
    function automatic logic [31:0] since_ms(input logic [31:0] now_t,
                                             input logic [31:0] then_t,
                                             input logic [31:0] mask);
        return (now_t - then_t) & mask;
    endfunction

    // Plain absolute difference of two stored timestamps.
    function automatic logic [31:0] dist_ms(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/auto_headlight_controller_core.sv =====
// Top level of the automatic headlight controller: input, state and result registers.
// Depends on ahc_pkg, ahc_sense, ahc_ctrl and assert_macros.svh.
//
//   Channel   Signals                          Direction
//   input     in_valid, in_stall, in_data      item beats into the block
//   output    out_valid, out_stall, out_data   result beats out of the block
//   config    cfg_wr_en, cfg_index, cfg_data   register writes, no read-back
//
// One beat is taken per cycle while in_stall is low; the result of each is registered.
// The whole step is combinational between the input register and the result register.
// Reset loads the documented register values and the initial state and clears valid flags.
// A stalled result holds the result register; the input register then holds one
// more beat, after which in_stall rises.
`include "assert_macros.svh"

module auto_headlight_controller_core #(
    parameter int TIME_BITS = 32,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ahc_pkg::item_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ahc_pkg::result_t                   out_data,
    input  logic                               cfg_wr_en,
    input  logic [ahc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data
);

    ahc_pkg::cfg_t      cfg_reg;
    ahc_pkg::item_t     item_reg;
    logic               item_valid_reg;
    ahc_pkg::sense_st_t sense_reg;
    ahc_pkg::sense_st_t sense_next;
    ahc_pkg::ctrl_st_t  ctrl_reg;
    ahc_pkg::ctrl_st_t  ctrl_next;
    ahc_pkg::result_t   result_next;
    ahc_pkg::result_t   out_reg;
    logic               out_valid_reg;
    logic [4:0]         ev;
    logic               advance;

    ahc_sense #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sense (
        .item (item_reg),
        .cfg  (cfg_reg),
        .st   (sense_reg),
        .nxt  (sense_next),
        .ev   (ev)
    );

    ahc_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .item      (item_reg),
        .cfg       (cfg_reg),
        .st        (ctrl_reg),
        .deb       (sense_next.debounced_level),
        .ev        (ev),
        .dark_now  (sense_next.dark_now),
        .fault_now (sense_next.fault_now),
        .nxt       (ctrl_next),
        .res       (result_next)
    );

    assign advance = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold <= 10'd790;
            cfg_reg.bright_threshold <= 10'd750;
            cfg_reg.leave_lock_ms <= 32'd40000;
            cfg_reg.leave_unlock_ms <= 32'd20000;
            cfg_reg.courtesy_ms <= 32'd20000;
            cfg_reg.follow_home_ms <= 32'd30000;
            cfg_reg.accessory_hold_ms <= 32'd600000;
            cfg_reg.invert_mask <= 5'd23;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ahc_pkg::REG_DARK_THRESHOLD:    cfg_reg.dark_threshold <= cfg_data[9:0];
                ahc_pkg::REG_BRIGHT_THRESHOLD:  cfg_reg.bright_threshold <= cfg_data[9:0];
                ahc_pkg::REG_LEAVE_LOCK_MS:     cfg_reg.leave_lock_ms <= cfg_data;
                ahc_pkg::REG_LEAVE_UNLOCK_MS:   cfg_reg.leave_unlock_ms <= cfg_data;
                ahc_pkg::REG_COURTESY_MS:       cfg_reg.courtesy_ms <= cfg_data;
                ahc_pkg::REG_FOLLOW_HOME_MS:    cfg_reg.follow_home_ms <= cfg_data;
                ahc_pkg::REG_ACCESSORY_HOLD_MS: cfg_reg.accessory_hold_ms <= cfg_data;
                ahc_pkg::REG_INVERT_MASK:       cfg_reg.invert_mask <= cfg_data[4:0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            sense_reg.debounced_level <= '1;
            sense_reg.last_raw_level <= '1;
            sense_reg.level_changed_time <= '0;
            sense_reg.dark_now <= 1'b0;
            sense_reg.dark_candidate <= 1'b0;
            sense_reg.dark_changed_time <= '0;
            sense_reg.fault_now <= 1'b0;
            sense_reg.fault_candidate <= 1'b0;
            sense_reg.fault_changed_time <= '0;
            sense_reg.ambient_ready <= 1'b0;
            ctrl_reg <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                sense_reg <= sense_next;
                ctrl_reg <= ctrl_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    `AHC_ASSERT_NEXT(a_step_gives_result, advance, out_valid_reg, "processed beat gave no result")
    `AHC_ASSERT_SAME(a_stall_needs_item, in_stall, item_valid_reg, "input stalled with no held beat")
    `AHC_ASSERT_SAME(a_fault_confirmed, $rose(sense_reg.fault_now), sense_reg.fault_candidate, "fault confirmed without candidate")

endmodule

// ===== rtl/ahc_sense.sv =====
// Input conditioning: switch normalisation and debouncing, ambient and sensor fault tracking.
// Depends on ahc_pkg.
module ahc_sense #(
    parameter int TIME_BITS = 32,
    parameter int SAMPLE_BITS = 10
) (
    input  ahc_pkg::item_t     item,
    input  ahc_pkg::cfg_t      cfg,
    input  ahc_pkg::sense_st_t st,
    output ahc_pkg::sense_st_t nxt,
    output logic [4:0]         ev
);

    localparam logic [31:0] TMASK = 32'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [11:0] SMASK = 12'((32'd1 << SAMPLE_BITS) - 32'd1);

    logic [31:0] now_t;
    logic [11:0] smp;
    logic [4:0]  raw;
    logic [10:0] thr_sum;
    logic [11:0] thr_mean;
    logic        is_fault;
    logic        target;

    always_comb
    begin
        now_t = item.now_ms & TMASK;
        smp = {2'b00, item.light_sample} & SMASK;
        raw = {item.ignition_level, item.door_level, item.turn_level,
               item.unlock_level, item.lock_level} ^ cfg.invert_mask;
        thr_sum = {1'b0, cfg.dark_threshold} + {1'b0, cfg.bright_threshold};
        thr_mean = {2'b00, thr_sum[10:1]};
        is_fault = (smp <= ahc_pkg::FAULT_LOW) || (smp >= ahc_pkg::FAULT_HIGH);
        target = 1'b0;
        nxt = st;
        ev = '0;

        if (!item.action)
        begin
            nxt.debounced_level = raw;
            nxt.last_raw_level = raw;
            for (int i = 0; i < ahc_pkg::NUM_SW; i++)
            begin
                nxt.level_changed_time[i] = now_t;
            end
        end

        if (!item.action || !st.ambient_ready)
        begin
            nxt.dark_now = smp >= thr_mean;
            nxt.dark_candidate = smp >= thr_mean;
            nxt.dark_changed_time = now_t;
            nxt.ambient_ready = 1'b1;
            nxt.fault_candidate = is_fault;
            nxt.fault_changed_time = now_t;
        end
        else
        begin
            if (is_fault != nxt.fault_candidate)
            begin
                nxt.fault_candidate = is_fault;
                nxt.fault_changed_time = now_t;
            end
            else if (is_fault != nxt.fault_now &&
                     ahc_pkg::since_ms(now_t, nxt.fault_changed_time, TMASK) >=
                     ahc_pkg::FAULT_STABLE_MS)
            begin
                nxt.fault_now = is_fault;
                if (!is_fault)
                begin
                    nxt.dark_changed_time = now_t;
                end
            end

            if (!nxt.fault_now)
            begin
                target = nxt.dark_now;
                if (!nxt.dark_now && smp >= {2'b00, cfg.dark_threshold})
                begin
                    target = 1'b1;
                end
                else if (nxt.dark_now && smp <= {2'b00, cfg.bright_threshold})
                begin
                    target = 1'b0;
                end

                if (target == nxt.dark_now)
                begin
                    nxt.dark_candidate = nxt.dark_now;
                end
                else if (target != nxt.dark_candidate)
                begin
                    nxt.dark_candidate = target;
                    nxt.dark_changed_time = now_t;
                end
                else if (ahc_pkg::since_ms(now_t, nxt.dark_changed_time, TMASK) >=
                         ahc_pkg::AMBIENT_STABLE_MS)
                begin
                    nxt.dark_now = target;
                    nxt.dark_candidate = target;
                end
            end
        end

        if (item.action)
        begin
            for (int i = 0; i < ahc_pkg::NUM_SW; i++)
            begin
                if (raw[i] != nxt.last_raw_level[i])
                begin
                    nxt.last_raw_level[i] = raw[i];
                    nxt.level_changed_time[i] = now_t;
                end
                if (ahc_pkg::since_ms(now_t, nxt.level_changed_time[i], TMASK) >=
                    ahc_pkg::DEBOUNCE_MS &&
                    nxt.debounced_level[i] != nxt.last_raw_level[i])
                begin
                    nxt.debounced_level[i] = nxt.last_raw_level[i];
                    ev[i] = 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/ahc_ctrl.sv =====
// Light control: door re-arming, pulse pairing, the four light and accessory timers, outputs.
// Depends on ahc_pkg; takes the conditioned inputs from ahc_sense.
module ahc_ctrl #(
    parameter int TIME_BITS = 32
) (
    input  ahc_pkg::item_t    item,
    input  ahc_pkg::cfg_t     cfg,
    input  ahc_pkg::ctrl_st_t st,
    input  logic [4:0]        deb,
    input  logic [4:0]        ev,
    input  logic              dark_now,
    input  logic              fault_now,
    output ahc_pkg::ctrl_st_t nxt,
    output ahc_pkg::result_t  res
);

    localparam logic [31:0] TMASK = 32'((64'd1 << TIME_BITS) - 64'd1);

    logic [31:0] now_t;
    logic        door_open_ev;
    logic        door_close_ev;
    logic        ign_on_ev;
    logic        ign_off_ev;
    logic        ign_on;
    logic        usable;
    logic        eligible;
    logic        lm;
    logic        um;
    logic [31:0] dur;

    always_comb
    begin
        now_t = item.now_ms & TMASK;
        door_open_ev = ev[ahc_pkg::SW_DOOR] && !deb[ahc_pkg::SW_DOOR];
        door_close_ev = ev[ahc_pkg::SW_DOOR] && deb[ahc_pkg::SW_DOOR];
        ign_on_ev = ev[ahc_pkg::SW_IGN] && !deb[ahc_pkg::SW_IGN];
        ign_off_ev = ev[ahc_pkg::SW_IGN] && deb[ahc_pkg::SW_IGN];
        ign_on = !deb[ahc_pkg::SW_IGN];
        usable = dark_now && !fault_now;
        eligible = !ign_on && deb[ahc_pkg::SW_DOOR] && usable;
        lm = 1'b0;
        um = 1'b0;
        dur = '0;
        nxt = st;

        if (!item.action)
        begin
            nxt.door_armed = deb[ahc_pkg::SW_DOOR];
            nxt.rearm_waiting = 1'b0;
            nxt.door_closed_time = now_t;
            nxt.drive_mode_prev = ign_on && usable;
            res.headlight_on = 1'b0;
            res.accessory_on = 1'b0;
        end
        else
        begin
            if (door_open_ev)
            begin
                nxt.door_armed = 1'b0;
                nxt.rearm_waiting = 1'b0;
            end
            else if (door_close_ev)
            begin
                nxt.rearm_waiting = 1'b1;
                nxt.door_closed_time = now_t;
            end
            else if (nxt.rearm_waiting && deb[ahc_pkg::SW_DOOR] &&
                     ahc_pkg::since_ms(now_t, nxt.door_closed_time, TMASK) >=
                     ahc_pkg::REARM_MS)
            begin
                nxt.rearm_waiting = 1'b0;
                nxt.door_armed = 1'b1;
            end

            if (door_open_ev && nxt.timer_running[ahc_pkg::T_ACC])
            begin
                nxt.accessory_door_cycle = 1'b1;
            end
            if (door_close_ev && nxt.timer_running[ahc_pkg::T_ACC] && nxt.accessory_door_cycle)
            begin
                nxt.timer_running[ahc_pkg::T_ACC] = 1'b0;
                nxt.accessory_door_cycle = 1'b0;
            end

            if (ign_on_ev)
            begin
                nxt.timer_running[ahc_pkg::T_LEAVE] = 1'b0;
                nxt.timer_running[ahc_pkg::T_COURTESY] = 1'b0;
                nxt.timer_running[ahc_pkg::T_FOLLOW] = 1'b0;
                if (nxt.timer_running[ahc_pkg::T_ACC])
                begin
                    nxt.timer_running[ahc_pkg::T_ACC] = 1'b0;
                    nxt.accessory_door_cycle = 1'b0;
                end
                nxt.pulse_pending = '0;
            end
            if (ign_off_ev)
            begin
                nxt.timer_running[ahc_pkg::T_ACC] = 1'b1;
                nxt.timer_start_time[ahc_pkg::T_ACC] = now_t;
                nxt.accessory_door_cycle = 1'b0;
            end

            if (!eligible)
            begin
                nxt.pulse_pending = '0;
            end
            else
            begin
                for (int i = 0; i < ahc_pkg::NUM_PULSES; i++)
                begin
                    if (nxt.pulse_pending[i] &&
                        ahc_pkg::since_ms(now_t, nxt.pulse_time[i], TMASK) >
                        ahc_pkg::PAIR_WINDOW_MS)
                    begin
                        nxt.pulse_pending[i] = 1'b0;
                    end
                    if (ev[i] && !deb[i])
                    begin
                        nxt.pulse_time[i] = now_t;
                        nxt.pulse_pending[i] = 1'b1;
                    end
                end
                lm = nxt.pulse_pending[ahc_pkg::SW_LOCK] && nxt.pulse_pending[ahc_pkg::SW_TURN] &&
                     ahc_pkg::dist_ms(nxt.pulse_time[ahc_pkg::SW_LOCK],
                                      nxt.pulse_time[ahc_pkg::SW_TURN]) <=
                     ahc_pkg::PAIR_WINDOW_MS;
                um = nxt.pulse_pending[ahc_pkg::SW_UNLOCK] &&
                     nxt.pulse_pending[ahc_pkg::SW_TURN] &&
                     ahc_pkg::dist_ms(nxt.pulse_time[ahc_pkg::SW_UNLOCK],
                                      nxt.pulse_time[ahc_pkg::SW_TURN]) <=
                     ahc_pkg::PAIR_WINDOW_MS;
                if (lm && um &&
                    ahc_pkg::dist_ms(nxt.pulse_time[ahc_pkg::SW_UNLOCK],
                                     nxt.pulse_time[ahc_pkg::SW_TURN]) <
                    ahc_pkg::dist_ms(nxt.pulse_time[ahc_pkg::SW_LOCK],
                                     nxt.pulse_time[ahc_pkg::SW_TURN]))
                begin
                    lm = 1'b0;
                end
                if (lm)
                begin
                    nxt.pulse_pending[ahc_pkg::SW_LOCK] = 1'b0;
                    nxt.pulse_pending[ahc_pkg::SW_TURN] = 1'b0;
                    nxt.leave_uses_unlock = 1'b0;
                    nxt.timer_running[ahc_pkg::T_LEAVE] = 1'b1;
                    nxt.timer_start_time[ahc_pkg::T_LEAVE] = now_t;
                end
                else if (um)
                begin
                    nxt.pulse_pending[ahc_pkg::SW_UNLOCK] = 1'b0;
                    nxt.pulse_pending[ahc_pkg::SW_TURN] = 1'b0;
                    nxt.leave_uses_unlock = 1'b1;
                    nxt.timer_running[ahc_pkg::T_LEAVE] = 1'b1;
                    nxt.timer_start_time[ahc_pkg::T_LEAVE] = now_t;
                end
            end

            if (!ign_on && usable && door_open_ev && nxt.door_armed)
            begin
                nxt.timer_running[ahc_pkg::T_COURTESY] = 1'b1;
                nxt.timer_start_time[ahc_pkg::T_COURTESY] = now_t;
            end
            if (ign_off_ev && usable && st.drive_mode_prev)
            begin
                nxt.timer_running[ahc_pkg::T_FOLLOW] = 1'b1;
                nxt.timer_start_time[ahc_pkg::T_FOLLOW] = now_t;
            end

            for (int t = 0; t < ahc_pkg::NUM_TIMERS; t++)
            begin
                case (t)
                    ahc_pkg::T_LEAVE:    dur = nxt.leave_uses_unlock ? cfg.leave_unlock_ms
                                                                     : cfg.leave_lock_ms;
                    ahc_pkg::T_COURTESY: dur = cfg.courtesy_ms;
                    ahc_pkg::T_FOLLOW:   dur = cfg.follow_home_ms;
                    default:             dur = cfg.accessory_hold_ms;
                endcase
                if (nxt.timer_running[t] &&
                    ahc_pkg::since_ms(now_t, nxt.timer_start_time[t], TMASK) >= dur)
                begin
                    nxt.timer_running[t] = 1'b0;
                    if (t == ahc_pkg::T_ACC)
                    begin
                        nxt.accessory_door_cycle = 1'b0;
                    end
                end
            end

            nxt.drive_mode_prev = ign_on && usable;
            res.headlight_on = nxt.drive_mode_prev ||
                               nxt.timer_running[ahc_pkg::T_LEAVE] ||
                               nxt.timer_running[ahc_pkg::T_COURTESY] ||
                               nxt.timer_running[ahc_pkg::T_FOLLOW];
            res.accessory_on = ign_on || nxt.timer_running[ahc_pkg::T_ACC];
        end
        res.sensor_fault = fault_now;
        res.ambient_is_dark = dark_now;
    end

endmodule
